>>> hdl/edc_pkg.sv
// Shared types, constants and the step program of the exponential decay convolver.
// Used by edc_sequencer, exponential_decay_convolver and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package edc_pkg;

    // Field widths of the streams, registers and internal words.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned OUT_W    = 48;
    localparam int unsigned WEIGHT_W = 24;
    localparam int unsigned DECAY_W  = 17;
    localparam int unsigned ACC_W    = 40;
    localparam int unsigned T_W      = 41;
    localparam int unsigned MUL_W    = 24;
    localparam int unsigned PROD_W   = 48;
    localparam int unsigned SUM_W    = 50;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned PC_W     = 4;

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_ZERO = 3'd0,
        REG_WEIGHT_ONE  = 3'd1,
        REG_WEIGHT_TWO  = 3'd2,
        REG_WEIGHT_THREE = 3'd3,
        REG_DECAY_ZERO  = 3'd4,
        REG_DECAY_ONE   = 3'd5,
        REG_DECAY_TWO   = 3'd6,
        REG_DECAY_THREE = 3'd7
    } cfg_reg_t;

    // Operand pair for the shared multiplier.
    typedef enum logic [4:0] {
        MUL_NONE = 5'b00001,
        MUL_TL   = 5'b00010,
        MUL_TH   = 5'b00100,
        MUL_AL   = 5'b01000,
        MUL_AH   = 5'b10000
    } mul_sel_t;

    // How the step counter moves after a step.
    typedef enum logic [2:0] {
        SEQ_NEXT = 3'b001,
        SEQ_LOOP = 3'b010,
        SEQ_END  = 3'b100
    } seq_t;

    // One control word of the step program.
    typedef struct packed {
        logic     t_en;     // t = acc[k] + previous sample
        mul_sel_t mul_sel;
        logic     part_en;  // keep the low partial product
        logic     u_en;     // join partial products of t * decay
        logic     a_en;     // add the new sample, saturate, write acc[k]
        logic     term_en;  // join partial products of acc * weight
        logic     sum_en;   // add the finished term to the running sum
        logic     fin;      // saturate the sum and load the output register
        seq_t     seq;
    } ctrl_t;

    localparam ctrl_t CTRL_IDLE = '{
        t_en: 1'b0, mul_sel: MUL_NONE, part_en: 1'b0, u_en: 1'b0, a_en: 1'b0,
        term_en: 1'b0, sum_en: 1'b0, fin: 1'b0, seq: SEQ_END
    };

    localparam logic [PC_W-1:0] PC_FIRST = 4'd0;
    localparam logic [PC_W-1:0] PC_FIN   = 4'd8;

    // The step program: steps 0 to 7 handle one component, step 8 closes the item.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = CTRL_IDLE;
        w.seq = SEQ_NEXT;
        case (pc)
            4'd0:
            begin
                w.t_en   = 1'b1;
                w.sum_en = 1'b1;
            end
            4'd1: w.mul_sel = MUL_TL;
            4'd2:
            begin
                w.mul_sel = MUL_TH;
                w.part_en = 1'b1;
            end
            4'd3: w.u_en = 1'b1;
            4'd4: w.a_en = 1'b1;
            4'd5: w.mul_sel = MUL_AL;
            4'd6:
            begin
                w.mul_sel = MUL_AH;
                w.part_en = 1'b1;
            end
            4'd7:
            begin
                w.term_en = 1'b1;
                w.seq     = SEQ_LOOP;
            end
            4'd8:
            begin
                w.fin = 1'b1;
                w.seq = SEQ_END;
            end
            default: w = CTRL_IDLE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/exponential_decay_convolver.sv
// Top level of the exponential decay convolver: handshakes, registers and datapath.
// Depends on edc_pkg and on edc_sequencer, which issues one control word per cycle unless held.
//
//  Channel   Direction  Transaction contents
//  s_axis    in         tdata = response_sample[15:0], tlast = last_sample
//  m_axis    out        tdata = model_value[47:0],     tlast = last_value
//  cfg       in         cfg_index selects weight 0..3 / decay 0..3, cfg_data is the value
//
// The block takes no new input until the closing step of the current one is done; each
// component runs eight steps of the program through the single shared 24 x 24 multiplier.
// Reset clears the accumulators, the previous sample, the weight and decay registers, the
// output valid flag and the sequencer. The next input is taken while a result waits in the
// output register; only the closing step stalls until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module exponential_decay_convolver #(
    parameter int NUM_COMPONENTS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // response_sample[15:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // model_value[47:0]
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int unsigned K_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int unsigned ACC_W  = edc_pkg::ACC_W;
    localparam int unsigned PROD_W = edc_pkg::PROD_W;
    localparam int unsigned MUL_W  = edc_pkg::MUL_W;
    localparam int unsigned SUM_W  = edc_pkg::SUM_W;
    localparam int unsigned OUT_W  = edc_pkg::OUT_W;

    edc_pkg::ctrl_t    ctrl;
    logic [K_W-1:0]    comp;
    logic              busy;
    logic              in_fire;
    logic              out_free;
    logic              fin_fire;
    logic              hold;

    logic [edc_pkg::WEIGHT_W-1:0] weight_reg [NUM_COMPONENTS];
    logic [edc_pkg::DECAY_W-1:0]  decay_reg  [NUM_COMPONENTS];
    logic [ACC_W-1:0]             acc_reg    [NUM_COMPONENTS];
    logic [edc_pkg::SAMPLE_W-1:0] prev_reg;

    logic [edc_pkg::SAMPLE_W-1:0] samp_reg;
    logic                         last_reg;
    logic [edc_pkg::T_W-1:0]      t_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [PROD_W-1:0]            part_reg;
    logic [PROD_W-1:0]            w_reg;
    logic [ACC_W-1:0]             a_reg;
    logic [SUM_W-1:0]             sum_reg;

    logic                         out_valid_reg;
    logic [OUT_W-1:0]             out_data_reg;
    logic                         out_last_reg;

    logic [MUL_W-1:0]             mul_a;
    logic [MUL_W-1:0]             mul_b;
    logic [ACC_W+1:0]             a_sum;
    logic [ACC_W-1:0]             a_sat;
    logic [SUM_W-1:0]             total;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign hold     = ctrl.fin && !out_free;
    assign fin_fire = ctrl.fin && out_free;

    assign s_axis_tready = !busy;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    edc_sequencer #(
        .NUM_COMPONENTS(NUM_COMPONENTS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .hold  (hold),
        .ctrl  (ctrl),
        .comp  (comp),
        .busy  (busy)
    );

    // Configuration registers; writes to components that are not built are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COMPONENTS; k++)
            begin
                weight_reg[k] <= '0;
                decay_reg[k]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int k = 0; k < NUM_COMPONENTS; k++)
            begin
                if (cfg_index == 3'(edc_pkg::REG_WEIGHT_ZERO) + 3'(k))
                begin
                    weight_reg[k] <= cfg_data;
                end
                if (cfg_index == 3'(edc_pkg::REG_DECAY_ZERO) + 3'(k))
                begin
                    decay_reg[k] <= cfg_data[edc_pkg::DECAY_W-1:0];
                end
            end
        end
    end

    // Shared multiplier operands; the product is registered.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            edc_pkg::MUL_TL:
            begin
                mul_a = t_reg[23:0];
                mul_b = {7'b0, decay_reg[comp]};
            end
            edc_pkg::MUL_TH:
            begin
                mul_a = {7'b0, t_reg[40:24]};
                mul_b = {7'b0, decay_reg[comp]};
            end
            edc_pkg::MUL_AL:
            begin
                mul_a = a_reg[23:0];
                mul_b = weight_reg[comp];
            end
            edc_pkg::MUL_AH:
            begin
                mul_a = {8'b0, a_reg[39:24]};
                mul_b = weight_reg[comp];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // New accumulator value: decayed value plus the current sample, clipped to 40 bits.
    assign a_sum = {1'b0, w_reg[40:0]} + {10'b0, samp_reg, 16'b0};
    assign a_sat = (a_sum[ACC_W+1:ACC_W] != 2'b00) ? {ACC_W{1'b1}} : a_sum[ACC_W-1:0];
    assign total = sum_reg + {2'b0, w_reg};

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            samp_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (ctrl.t_en)
        begin
            t_reg <= {1'b0, acc_reg[comp]} + {9'b0, prev_reg, 16'b0};
        end
        if (ctrl.mul_sel != edc_pkg::MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.part_en)
        begin
            part_reg <= prod_reg;
        end
        // The high partial product carries a 2^24 weight, so each join is a shift and add.
        if (in_fire)
        begin
            w_reg <= '0;
        end
        else if (ctrl.u_en)
        begin
            w_reg <= {prod_reg[40:0], 7'b0} + {24'b0, part_reg[40:17]};
        end
        else if (ctrl.term_en)
        begin
            w_reg <= {prod_reg[39:0], 8'b0} + {16'b0, part_reg[47:16]};
        end
        if (ctrl.a_en)
        begin
            a_reg <= a_sat;
        end
        if (in_fire)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.sum_en)
        begin
            sum_reg <= total;
        end
        if (fin_fire)
        begin
            out_data_reg <= (total[SUM_W-1:OUT_W] != 2'b00) ? {OUT_W{1'b1}} : total[OUT_W-1:0];
            out_last_reg <= last_reg;
        end
    end

    // Curve state: accumulators and the previous sample; a last flag clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COMPONENTS; k++)
            begin
                acc_reg[k] <= '0;
            end
            prev_reg <= '0;
        end
        else if (fin_fire)
        begin
            if (last_reg)
            begin
                for (int k = 0; k < NUM_COMPONENTS; k++)
                begin
                    acc_reg[k] <= '0;
                end
                prev_reg <= '0;
            end
            else
            begin
                prev_reg <= samp_reg;
            end
        end
        else if (ctrl.a_en)
        begin
            acc_reg[comp] <= a_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/edc_sequencer.sv
// Step counter and component counter that walk the step program of edc_pkg.
// Depends on edc_pkg for the control word type and the program table.
`timescale 1ns / 1ps
`default_nettype none

module edc_sequencer #(
    parameter int NUM_COMPONENTS = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                hold,
    output edc_pkg::ctrl_t           ctrl,
    output logic [((NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1)-1:0] comp,
    output logic                     busy
);

    localparam int unsigned K_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam logic [K_W-1:0] K_LAST = K_W'(NUM_COMPONENTS - 1);

    logic                      busy_reg;
    logic [edc_pkg::PC_W-1:0]  pc_reg;
    logic [K_W-1:0]            k_reg;
    edc_pkg::ctrl_t            word;

    assign word = edc_pkg::ucode(pc_reg);
    assign ctrl = busy_reg ? word : edc_pkg::CTRL_IDLE;
    assign comp = k_reg;
    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= edc_pkg::PC_FIRST;
            k_reg    <= '0;
        end
        else if (!busy_reg)
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= edc_pkg::PC_FIRST;
                k_reg    <= '0;
            end
        end
        else if (!hold)
        begin
            case (word.seq)
                edc_pkg::SEQ_NEXT: pc_reg <= pc_reg + 1'b1;
                edc_pkg::SEQ_LOOP:
                begin
                    if (k_reg == K_LAST)
                    begin
                        pc_reg <= edc_pkg::PC_FIN;
                    end
                    else
                    begin
                        pc_reg <= edc_pkg::PC_FIRST;
                        k_reg  <= k_reg + 1'b1;
                    end
                end
                edc_pkg::SEQ_END: busy_reg <= 1'b0;
                default: busy_reg <= 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/edc_checker.sv
// Port-level checks on the exponential decay convolver and the bind that attaches them.
// Depends only on the top-level ports of exponential_decay_convolver.
`timescale 1ns / 1ps
`default_nettype none

module edc_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A result waiting on the output side keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // Once an input is taken the block is not ready again straight away while it works on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input accepted again while an item is in work");

    // A new result only appears as the block finishes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready) && s_axis_tready)
        else $error("result appeared outside the end of an item");

    // No result appears in the cycle right after an input is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too soon after an input");

endmodule

bind exponential_decay_convolver edc_port_checker u_edc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/sv/edc_checker.sv
// Scoreboard for the exponential decay convolver: predicts every result and checks it.
// Watches the cfg, s_axis and m_axis ports of the block; depends on edc_pkg.
`timescale 1ns / 1ps

module edc_checker #(
    parameter int NUM_COMPONENTS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [edc_pkg::SAMPLE_W-1:0]   s_axis_tdata,
    input  logic                           s_axis_tlast,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [edc_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [edc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             open_bins,
    output int                             mismatch_count
);

    localparam int unsigned MAX_COMPONENTS = 4;
    localparam logic [41:0] ACC_CEIL = (42'd1 << edc_pkg::ACC_W) - 42'd1;
    localparam logic [edc_pkg::SUM_W-1:0] OUT_CEIL = (50'd1 << edc_pkg::OUT_W) - 50'd1;

    typedef struct packed {
        logic [edc_pkg::OUT_W-1:0] model_value;
        logic                      last_value;
    } bin_result_t;

    logic [edc_pkg::WEIGHT_W-1:0] weight_q [MAX_COMPONENTS];
    logic [edc_pkg::DECAY_W-1:0]  decay_q  [MAX_COMPONENTS];
    logic [edc_pkg::ACC_W-1:0]    acc_q    [MAX_COMPONENTS];
    logic [edc_pkg::SAMPLE_W-1:0] prev_sample_q;
    bin_result_t                  expected_bins [$];

    task automatic clear_curve();
        for (int k = 0; k < MAX_COMPONENTS; k++)
        begin
            acc_q[k] = '0;
        end
        prev_sample_q = '0;
    endtask

    // Advances every decay component by one histogram bin and forms the weighted sum.
    task automatic convolve_bin(input logic [edc_pkg::SAMPLE_W-1:0] smp, input logic lst,
                                output bin_result_t res);
        logic [edc_pkg::T_W-1:0]   t;
        logic [57:0]               decayed;
        logic [41:0]               a;
        logic [63:0]               term;
        logic [edc_pkg::SUM_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < NUM_COMPONENTS && k < MAX_COMPONENTS; k++)
        begin
            t       = edc_pkg::T_W'(acc_q[k]) + (edc_pkg::T_W'(prev_sample_q) << 16);
            decayed = 58'(t) * 58'(decay_q[k]);
            a       = 42'(decayed >> 17) + (42'(smp) << 16);
            if (a > ACC_CEIL)
                a = ACC_CEIL;
            acc_q[k] = a[edc_pkg::ACC_W-1:0];
            term     = 64'(acc_q[k]) * 64'(weight_q[k]);
            sum      = sum + edc_pkg::SUM_W'(term >> 16);
        end
        if (sum > OUT_CEIL)
            sum = OUT_CEIL;
        prev_sample_q = smp;
        // The last bin of a curve still sees the old state; the clear follows it.
        if (lst)
            clear_curve();
        res.model_value = sum[edc_pkg::OUT_W-1:0];
        res.last_value  = lst;
    endtask

    always @(posedge clk)
    begin : monitor
        bin_result_t res;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_COMPONENTS; k++)
            begin
                weight_q[k] = '0;
                decay_q[k]  = '0;
            end
            clear_curve();
            expected_bins.delete();
            mismatch_count = 0;
            open_bins <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index < edc_pkg::REG_DECAY_ZERO)
                    weight_q[cfg_index - edc_pkg::REG_WEIGHT_ZERO] =
                        cfg_data[edc_pkg::WEIGHT_W-1:0];
                else
                    decay_q[cfg_index - edc_pkg::REG_DECAY_ZERO] =
                        cfg_data[edc_pkg::DECAY_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                convolve_bin(s_axis_tdata, s_axis_tlast, res);
                expected_bins.push_back(res);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bins.size() == 0)
                begin
                    $error("unexpected result transaction: model_value %0h last_value %0b",
                           m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end
                else
                begin
                    res = expected_bins.pop_front();
                    if (m_axis_tdata !== res.model_value)
                    begin
                        $error("model_value mismatch: expected %0h, actual %0h",
                               res.model_value, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== res.last_value)
                    begin
                        $error("last_value mismatch: expected %0b, actual %0b",
                               res.last_value, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
            open_bins <= expected_bins.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the exponential decay convolver testbench: clock, reset, stimulus and verdict.
// Depends on edc_pkg, the exponential_decay_convolver block and the edc_checker scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int COMPONENTS   = 4;
    localparam int PHASE_BINS   = 96;
    localparam int RANDOM_PHASES = 10;

    typedef enum int {
        CFG_RANDOM,
        CFG_SLOW_DECAY,
        CFG_MIXED_EXTREMES,
        CFG_ALL_MAX,
        CFG_UNIT_WEIGHT
    } cfg_mode_t;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_HIGH,
        SHAPE_LOW,
        SHAPE_EXTREME
    } curve_shape_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [edc_pkg::SAMPLE_W-1:0]   s_axis_tdata = '0;     // response_sample[15:0]
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [edc_pkg::OUT_W-1:0]      m_axis_tdata;          // model_value[47:0]
    logic                           m_axis_tlast;
    logic                           cfg_we = 1'b0;
    logic [edc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [edc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                             open_bins;
    int                             mismatch_count;
    bit                             steady_flow = 1'b0;
    int                             phase_bins;

    exponential_decay_convolver #(
        .NUM_COMPONENTS(COMPONENTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    edc_checker #(
        .NUM_COMPONENTS(COMPONENTS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .open_bins     (open_bins),
        .mismatch_count(mismatch_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 37);
    end

    // Returns in the time step of the handshake with tvalid still high; the next call
    // or settle() must follow in that same step so the bin is not taken twice.
    task automatic send_bin(input logic [edc_pkg::SAMPLE_W-1:0] smp, input logic lst);
        while (!steady_flow && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        phase_bins++;
    endtask

    // Drains the block so that the registers may be rewritten.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (open_bins != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input edc_pkg::cfg_reg_t idx,
                             input logic [edc_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input cfg_mode_t mode);
        logic [edc_pkg::CFG_DATA_W-1:0] w;
        logic [edc_pkg::CFG_DATA_W-1:0] d;
        for (int k = 0; k < 4; k++)
        begin
            case (mode)
                CFG_ALL_MAX:
                begin
                    w = '1;
                    d = '1;
                end
                CFG_UNIT_WEIGHT:
                begin
                    // Upper data bits of the decay word lie beyond the register and are dropped.
                    w = 24'h010000;
                    d = 24'hFE0000 | 24'h010000;
                end
                CFG_SLOW_DECAY:
                begin
                    w = 24'($urandom);
                    d = {7'($urandom), 17'($urandom_range(125000, 131071))};
                end
                CFG_MIXED_EXTREMES:
                begin
                    case ($urandom_range(2))
                        0: w = '0;
                        1: w = '1;
                        default: w = 24'($urandom);
                    endcase
                    case ($urandom_range(2))
                        0: d = '0;
                        1: d = 24'h01FFFF;
                        default: d = 24'($urandom);
                    endcase
                end
                default:
                begin
                    w = 24'($urandom);
                    d = 24'($urandom);
                end
            endcase
            write_reg(edc_pkg::cfg_reg_t'(int'(edc_pkg::REG_WEIGHT_ZERO) + k), w);
            write_reg(edc_pkg::cfg_reg_t'(int'(edc_pkg::REG_DECAY_ZERO) + k), d);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_curve(input int len, input curve_shape_t shape);
        logic [edc_pkg::SAMPLE_W-1:0] smp;
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_HIGH:    smp = 16'($urandom_range(60000, 65535));
                SHAPE_LOW:     smp = 16'($urandom_range(0, 255));
                SHAPE_EXTREME: smp = $urandom_range(1) ? '1 : '0;
                default:       smp = 16'($urandom);
            endcase
            send_bin(smp, i == len - 1);
        end
    endtask

    initial
    begin
        cfg_mode_t mode;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at their reset value: every result is zero.
        send_bin(16'h0000, 1'b0);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'hFFFF, 1'b1);
        settle();

        program_regs(CFG_ALL_MAX);
        send_bin(16'hFFFF, 1'b1);
        send_bin(16'h0000, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'hFFFF, 1'b1);
        settle();

        program_regs(CFG_UNIT_WEIGHT);
        send_bin(16'h8000, 1'b0);
        send_bin(16'h0001, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'hFFFF, 1'b1);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mode = cfg_mode_t'(phase % 5);
            steady_flow = (phase == 4);
            program_regs(mode);
            phase_bins = 0;
            while (phase_bins < PHASE_BINS)
            begin
                // Long curves of large counts under slow decay drive the accumulators
                // and the output sum into saturation.
                if ((mode == CFG_ALL_MAX || mode == CFG_SLOW_DECAY) && $urandom_range(3) == 0)
                    send_curve($urandom_range(130, 180), SHAPE_HIGH);
                else
                    send_curve($urandom_range(1, 24), curve_shape_t'($urandom_range(3)));
            end
            settle();
        end
        steady_flow = 1'b0;

        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("exponential_decay_convolver regression: pass");
        else
            $display("exponential_decay_convolver regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("exponential_decay_convolver regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/edc_pkg.sv
hdl/edc_sequencer.sv
hdl/exponential_decay_convolver.sv
hdl/edc_checker.sv
tb/sv/edc_checker.sv
tb/sv/tb_top.sv
